// ===== hdl/lookds_pkg.sv =====
package lookds_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned TrackW = 16;
  localparam int unsigned TagW   = 8;
  localparam int unsigned CountW = 5;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_SERVICE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_SERVED   = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic              command;
    logic [TrackW-1:0] track;
    logic [TagW-1:0]   request_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TrackW-1:0] served_track;
    logic [TagW-1:0]   served_tag;
    logic              sweeping_up;
    logic [CountW-1:0] pending_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic enq;       // append latched request
    logic scan;      // table scan step
    logic pick;      // select winner, move head
    logic shift;     // close the gap left by the winner
    logic dec;       // drop one from the pending count
    logic load_out;  // load output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_service;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/lookds_ctrl.sv =====
module lookds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lookds_pkg::dp_stat_t stat_i,
  output lookds_pkg::ctrl_cmd_t cmd_o
);

  lookds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lookds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lookds_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (!stat_i.is_service) begin
            state_d = lookds_pkg::S_ENQ;
          end else if (stat_i.empty) begin
            state_d = lookds_pkg::S_RESULT;
          end else begin
            state_d = lookds_pkg::S_SCAN;
          end
        end
      end
      lookds_pkg::S_ENQ: begin
        state_d = lookds_pkg::S_RESULT;
      end
      lookds_pkg::S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = lookds_pkg::S_PICK;
        end
      end
      lookds_pkg::S_PICK: begin
        state_d = lookds_pkg::S_SHIFT;
      end
      lookds_pkg::S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = lookds_pkg::S_RESULT;
        end
      end
      lookds_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          state_d = lookds_pkg::S_IDLE;
        end
      end
      default: state_d = lookds_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lookds_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      lookds_pkg::S_ENQ:   cmd_o.enq  = 1'b1;
      lookds_pkg::S_SCAN:  cmd_o.scan = 1'b1;
      lookds_pkg::S_PICK:  cmd_o.pick = 1'b1;
      lookds_pkg::S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.dec   = stat_i.shift_done;
      end
      lookds_pkg::S_RESULT: cmd_o.load_out = stat_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// ===== hdl/lookds_dp.sv =====
module lookds_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lookds_pkg::in_item_t  in_item_i,
  input  logic                  out_stall_i,
  input  lookds_pkg::ctrl_cmd_t cmd_i,
  output lookds_pkg::dp_stat_t  stat_o,
  output logic                  out_valid_o,
  output lookds_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Request table, arrival order
  logic [TRACK_BITS-1:0] trk_mem [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]   tag_mem [QUEUE_DEPTH];

  logic [TRACK_BITS-1:0] rd_trk_q;
  logic [TAG_BITS-1:0]   rd_tag_q;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [IdxW-1:0]       mem_raddr;
  logic [TRACK_BITS-1:0] mem_wtrk;
  logic [TAG_BITS-1:0]   mem_wtag;

  // Architectural state
  logic [CntW-1:0]       total_q;
  logic [TRACK_BITS-1:0] head_q;
  logic                  dir_q;

  // Latched request
  logic [TRACK_BITS-1:0] item_trk_q;
  logic [TAG_BITS-1:0]   item_tag_q;
  logic [TRACK_BITS+lookds_pkg::TrackW-1:0] in_trk_ext;
  logic [TAG_BITS+lookds_pkg::TagW-1:0]     in_tag_ext;

  // Scan
  logic [CntW-1:0]       idx_q;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  up_found_q, dn_found_q;
  logic [TRACK_BITS-1:0] up_trk_q, dn_trk_q;
  logic [TAG_BITS-1:0]   up_tag_q, dn_tag_q;
  logic [IdxW-1:0]       up_idx_q, dn_idx_q;
  logic                  up_better, dn_better;

  // Pick and shift
  logic                  pick_up;
  logic [IdxW-1:0]       pick_idx;
  logic [CntW-1:0]       ptr_q;
  logic                  wr_pend_q;
  logic [IdxW-1:0]       wr_addr_q;
  logic                  full;

  // Result
  logic [1:0]            res_status_q;
  logic [TRACK_BITS-1:0] res_trk_q;
  logic [TAG_BITS-1:0]   res_tag_q;
  logic                  out_valid_q;
  lookds_pkg::out_item_t out_item_q;
  logic [TRACK_BITS+lookds_pkg::TrackW-1:0] res_trk_ext;
  logic [TAG_BITS+lookds_pkg::TagW-1:0]     res_tag_ext;
  logic [CntW+lookds_pkg::CountW-1:0]       cnt_ext;

  assign full = (total_q == CntW'(QUEUE_DEPTH));

  assign in_trk_ext  = {{TRACK_BITS{1'b0}}, in_item_i.track};
  assign in_tag_ext  = {{TAG_BITS{1'b0}}, in_item_i.request_tag};
  assign res_trk_ext = {{lookds_pkg::TrackW{1'b0}}, res_trk_q};
  assign res_tag_ext = {{lookds_pkg::TagW{1'b0}}, res_tag_q};
  assign cnt_ext     = {{lookds_pkg::CountW{1'b0}}, total_q};

  // Memory ports: enqueue and shift writes never coincide
  always_comb begin
    mem_we    = (cmd_i.enq && !full) || wr_pend_q;
    mem_waddr = cmd_i.enq ? total_q[IdxW-1:0] : wr_addr_q;
    mem_wtrk  = cmd_i.enq ? item_trk_q : rd_trk_q;
    mem_wtag  = cmd_i.enq ? item_tag_q : rd_tag_q;
    mem_raddr = cmd_i.shift ? ptr_q[IdxW-1:0] : idx_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      trk_mem[mem_waddr] <= mem_wtrk;
      tag_mem[mem_waddr] <= mem_wtag;
    end
    rd_trk_q <= trk_mem[mem_raddr];
    rd_tag_q <= tag_mem[mem_raddr];
  end

  // Nearest at/above head and nearest at/below head, oldest wins ties
  assign up_better = rd_vld_q && (rd_trk_q >= head_q) &&
                     (!up_found_q || (rd_trk_q < up_trk_q));
  assign dn_better = rd_vld_q && (rd_trk_q <= head_q) &&
                     (!dn_found_q || (rd_trk_q > dn_trk_q));

  // Keep direction if something lies ahead, otherwise reverse
  assign pick_up  = dir_q ? up_found_q : !dn_found_q;
  assign pick_idx = pick_up ? up_idx_q : dn_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      head_q      <= '0;
      dir_q       <= 1'b1;
      idx_q       <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      wr_pend_q   <= 1'b0;
      up_found_q  <= 1'b0;
      dn_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.scan && (idx_q < total_q);
      wr_pend_q <= cmd_i.shift && (ptr_q < total_q);
      if (cmd_i.accept) begin
        idx_q      <= '0;
        up_found_q <= 1'b0;
        dn_found_q <= 1'b0;
      end
      if (cmd_i.scan && (idx_q < total_q)) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (up_better) begin
        up_found_q <= 1'b1;
      end
      if (dn_better) begin
        dn_found_q <= 1'b1;
      end
      if (cmd_i.enq && !full) begin
        total_q <= total_q + CntW'(1);
      end
      if (cmd_i.dec) begin
        total_q <= total_q - CntW'(1);
      end
      if (cmd_i.pick) begin
        dir_q  <= pick_up;
        head_q <= pick_up ? up_trk_q : dn_trk_q;
        ptr_q  <= CntW'(pick_idx) + CntW'(1);
      end
      if (cmd_i.shift && (ptr_q < total_q)) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_trk_q   <= in_trk_ext[TRACK_BITS-1:0];
      item_tag_q   <= in_tag_ext[TAG_BITS-1:0];
      res_status_q <= lookds_pkg::STAT_EMPTY;
      res_trk_q    <= '0;
      res_tag_q    <= '0;
    end
    if (cmd_i.enq) begin
      res_status_q <= full ? lookds_pkg::STAT_FULL : lookds_pkg::STAT_ENQUEUED;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q[IdxW-1:0];
    end
    if (up_better) begin
      up_trk_q <= rd_trk_q;
      up_tag_q <= rd_tag_q;
      up_idx_q <= rd_idx_q;
    end
    if (dn_better) begin
      dn_trk_q <= rd_trk_q;
      dn_tag_q <= rd_tag_q;
      dn_idx_q <= rd_idx_q;
    end
    if (cmd_i.pick) begin
      res_status_q <= lookds_pkg::STAT_SERVED;
      res_trk_q    <= pick_up ? up_trk_q : dn_trk_q;
      res_tag_q    <= pick_up ? up_tag_q : dn_tag_q;
    end
    if (cmd_i.shift) begin
      wr_addr_q <= IdxW'(ptr_q - CntW'(1));
    end
    if (cmd_i.load_out) begin
      out_item_q.status        <= res_status_q;
      out_item_q.served_track  <= res_trk_ext[lookds_pkg::TrackW-1:0];
      out_item_q.served_tag    <= res_tag_ext[lookds_pkg::TagW-1:0];
      out_item_q.sweeping_up   <= dir_q;
      out_item_q.pending_count <= cnt_ext[lookds_pkg::CountW-1:0];
    end
  end

  always_comb begin
    stat_o.is_service = (in_item_i.command == lookds_pkg::CMD_SERVICE);
    stat_o.empty      = (total_q == '0);
    stat_o.scan_done  = (idx_q == total_q);
    stat_o.shift_done = (ptr_q >= total_q);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(QUEUE_DEPTH))
    else $error("pending count above table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CntW'(rd_idx_q) < total_q))
    else $error("scan read beyond pending entries");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (CntW'(wr_addr_q) + CntW'(1) < total_q))
    else $error("shift write beyond pending entries");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enq && !full) |=> (total_q == $past(total_q) + CntW'(1)))
    else $error("enqueue did not bump pending count");

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> (up_found_q || dn_found_q))
    else $error("service pick with no candidate");

endmodule

// ===== hdl/look_disk_request_scheduler.sv =====
// LOOK disk-head request scheduler.
// Input channel (in_valid_i / in_stall_o / in_item_i): one transaction is
// either an enqueue (track, tag) or a service request. Output channel
// (out_valid_o / out_stall_i / out_item_o): exactly one result transaction
// per input transaction, in order.
// Sequence: an enqueue is appended to the table and its result loaded
// into the output register; an empty-table service result is loaded
// directly. A service on N pending entries scans them once through the
// table's registered read port, picks the winner, closes the gap behind
// the served entry one entry per cycle and then loads the output register.
// Throughput: one transaction is in work at a time; the next is accepted
// the cycle after the previous result is loaded.
// Reset clears the pending count, parks the head at track 0 and sets the
// sweep upward; table contents are not cleared since only entries below
// the pending count are read.
// A stalled output holds its result; a finished transaction waits for the
// output register, and input stays stalled meanwhile.
module look_disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lookds_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lookds_pkg::out_item_t out_item_o
);

  // Command and status between the sequencer and the table datapath
  lookds_pkg::ctrl_cmd_t cmd;
  lookds_pkg::dp_stat_t  stat;

  lookds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table memory, head/direction state, scan and shift logic, output register
  lookds_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_BITS  (TRACK_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/look_disk_request_scheduler_tb.sv =====
module look_disk_request_scheduler_tb;

  // Payload field widths
  localparam int unsigned TrackW = lookds_pkg::TrackW;
  localparam int unsigned TagW   = lookds_pkg::TagW;
  localparam int unsigned CountW = lookds_pkg::CountW;
  // Table size of the block as instantiated (default parameters)
  localparam int unsigned Depth = 16;
  // Random enqueue/service transactions after the directed part
  localparam int unsigned RandomItems = 500;
  // Cycles with no transaction on either channel before the run is abandoned.
  // This leaves a wide margin over a full-table service, stalls and sender
  // gaps included.
  localparam int unsigned IdleLimit = 2000;
  // Drain time after the last result, beyond the block's worst latency
  localparam int unsigned DrainCycles = 60;
  // Report only the first few mismatches in detail
  localparam int unsigned ReportMax = 10;
  // Mid-range track, useful for splitting the table across the head
  localparam logic [TrackW-1:0] MidTrack = 16'd32768;

  // Tracks for the directed table fill: both extremes, mid-range, ties and
  // neighbors of the head.
  localparam logic [TrackW-1:0] FillTracks [Depth] = '{
    16'd0, 16'd65535, 16'd40, 16'd40, 16'd100, 16'd7, MidTrack, 16'd1,
    16'd65534, 16'd200, 16'd40, 16'd99, 16'd101, 16'd12345, 16'd255, 16'd256
  };

  // Scoreboard: models the LOOK scheduler and holds the predicted results
  // in transaction order.
  class sched_scoreboard;
    logic [TrackW-1:0]     track_table [Depth];
    logic [TagW-1:0]       tag_table   [Depth];
    int unsigned           pending_total;
    logic [TrackW-1:0]     head_track;
    logic                  sweep_up;
    lookds_pkg::out_item_t predicted_results [$];
    int unsigned           mismatches;

    function new();
      pending_total = 0;
      head_track    = '0;
      sweep_up      = 1'b1;
      mismatches    = 0;
    endfunction

    // Nearest pending track at or beyond the head in the given direction;
    // strict compare keeps the oldest entry on ties. -1 when nothing is ahead.
    function int nearest_index(logic up);
      int                best;
      logic [TrackW-1:0] best_gap;
      logic [TrackW-1:0] track_gap;
      best     = -1;
      best_gap = '0;
      for (int i = 0; i < pending_total; i++) begin
        if (up) begin
          if (track_table[i] < head_track) continue;
          track_gap = track_table[i] - head_track;
        end else begin
          if (track_table[i] > head_track) continue;
          track_gap = head_track - track_table[i];
        end
        if (best < 0 || track_gap < best_gap) begin
          best     = i;
          best_gap = track_gap;
        end
      end
      return best;
    endfunction

    // Accepted input transaction: advance the model and queue its result.
    function void note_request(lookds_pkg::in_item_t req);
      lookds_pkg::out_item_t res;
      int                    pick;
      res = '0;
      if (req.command == lookds_pkg::CMD_ENQUEUE) begin
        if (pending_total >= Depth) begin
          res.status = lookds_pkg::STAT_FULL;
        end else begin
          track_table[pending_total] = req.track;
          tag_table[pending_total]   = req.request_tag;
          pending_total++;
          res.status = lookds_pkg::STAT_ENQUEUED;
        end
      end else if (pending_total == 0) begin
        res.status = lookds_pkg::STAT_EMPTY;
      end else begin
        pick = nearest_index(sweep_up);
        if (pick < 0) begin
          // nothing ahead: reverse, then every entry qualifies
          sweep_up = ~sweep_up;
          pick     = nearest_index(sweep_up);
        end
        res.status       = lookds_pkg::STAT_SERVED;
        res.served_track = track_table[pick];
        res.served_tag   = tag_table[pick];
        for (int k = pick; k + 1 < pending_total; k++) begin
          track_table[k] = track_table[k + 1];
          tag_table[k]   = tag_table[k + 1];
        end
        pending_total--;
        head_track = res.served_track;
      end
      res.sweeping_up   = sweep_up;
      res.pending_count = CountW'(pending_total);
      predicted_results.push_back(res);
    endfunction

    // Accepted output transaction: compare with the oldest prediction.
    function void check_result(lookds_pkg::out_item_t got);
      lookds_pkg::out_item_t want;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: status %0d track %0d tag %0d up %0d count %0d",
                   got.status, got.served_track, got.served_tag, got.sweeping_up,
                   got.pending_count);
        return;
      end
      want = predicted_results.pop_front();
      if (got.status !== want.status || got.served_track !== want.served_track ||
          got.served_tag !== want.served_tag || got.sweeping_up !== want.sweeping_up ||
          got.pending_count !== want.pending_count) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("mismatch: status %0d/%0d track %0d/%0d tag %0d/%0d up %0d/%0d count %0d/%0d",
                   want.status, got.status, want.served_track, got.served_track,
                   want.served_tag, got.served_tag, want.sweeping_up, got.sweeping_up,
                   want.pending_count, got.pending_count);
      end
    endfunction

    function int unsigned outstanding();
      return predicted_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  lookds_pkg::in_item_t  in_item;
  logic                  out_valid;
  logic                  out_stall;
  lookds_pkg::out_item_t out_item;

  sched_scoreboard sb;

  // Sender burst bookkeeping
  int unsigned burst_left;
  // Receiver stall pattern: mode held for a stretch of cycles
  int unsigned stall_mode;
  int unsigned stall_cycles;
  int unsigned idle_cycles;

  look_disk_request_scheduler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Monitor: both channels are sampled at the rising edge, before any
  // nonblocking update of that edge lands, so the view is race free.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Receiver: when the stall countdown expires, pick a new stall mode. Mode 0 never stalls,
  // 1 stalls at random, 2 holds long stall/no-stall runs, 3 alternates.
  always @(posedge clk) begin
    if (stall_cycles == 0) begin
      stall_mode   <= $urandom_range(0, 3);
      stall_cycles <= 50;
    end else begin
      stall_cycles <= stall_cycles - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
      default: out_stall <= ~out_stall;
    endcase
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until accepted. Called at a rising
  // edge. After a burst of random length, valid may drop for a random gap.
  task automatic send_item(lookds_pkg::in_item_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic enqueue_request(logic [TrackW-1:0] trk, logic [TagW-1:0] tag);
    lookds_pkg::in_item_t item;
    item.command     = lookds_pkg::CMD_ENQUEUE;
    item.track       = trk;
    item.request_tag = tag;
    send_item(item);
  endtask

  // Track and tag are don't-care for a service; randomize them anyway.
  task automatic service_request();
    lookds_pkg::in_item_t item;
    item.command     = lookds_pkg::CMD_SERVICE;
    item.track       = TrackW'($urandom);
    item.request_tag = TagW'($urandom);
    send_item(item);
  endtask

  initial begin
    int unsigned       failures;
    int unsigned       enq_pct;
    bit                clustered;
    logic [TrackW-1:0] cluster_base;
    logic [TrackW-1:0] trk;

    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    stall_mode   = 0;
    stall_cycles = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    enq_pct      = 50;
    clustered    = 1'b0;
    cluster_base = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Service on an empty table: status empty, head stays.
    service_request();
    // Single request ahead of the head: served at once, sweep stays up.
    enqueue_request(16'd500, 8'h0f);
    service_request();
    // Single request behind the head: sweep reverses, then serves.
    enqueue_request(16'd100, 8'hf0);
    service_request();
    // Request right at the head's track while sweeping down: distance zero.
    enqueue_request(16'd100, 8'h33);
    service_request();
    // Fill the table (ties, extremes, head's own track), then overflow it.
    for (int i = 0; i < Depth; i++)
      enqueue_request(FillTracks[i], TagW'(i * 17));
    enqueue_request(16'hffff, 8'hff);

    // Random part in phases of 40: the enqueue share moves the table between
    // full and empty; clustered tracks give ties and hits on the head track.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        clustered    = 1'($urandom_range(0, 1));
        cluster_base = TrackW'($urandom);
      end
      if ($urandom_range(1, 100) <= enq_pct) begin
        trk = clustered ? TrackW'(cluster_base + $urandom_range(0, 15)) : TrackW'($urandom);
        enqueue_request(trk, TagW'($urandom));
      end else begin
        service_request();
      end
    end
    in_valid <= 1'b0;
    // Let the monitor note the last accepted transaction first.
    @(posedge clk);

    // Wait for every predicted result, then give stray ones time to show.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    failures = sb.mismatches + sb.outstanding();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
